[rtl/core/i2p_pkg.sv]
package i2p_pkg;

   // operator stack tags
   localparam logic [2:0] TAG_OPEN  = 3'd0;
   localparam logic [2:0] TAG_PLUS  = 3'd1;
   localparam logic [2:0] TAG_MINUS = 3'd2;
   localparam logic [2:0] TAG_MUL   = 3'd3;
   localparam logic [2:0] TAG_DIV   = 3'd4;
   localparam logic [2:0] TAG_POW   = 3'd5;

   // ascii codes
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_POW   = 8'h5E;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic       end_mark;
      logic       err_active;
      logic       is_alnum;
      logic       is_open;
      logic       is_close;
      logic       is_op;
      logic       empty;
      logic       full;
      logic       top_open;
      logic       pop_ok;
      logic       close_last;
      logic       op_last;
      logic       out_free;
   } status_type;

   typedef struct packed {
      logic       take;
      logic       push;
      logic       pop_emit;
      logic       drop_open;
      logic       emit_alnum;
      logic       done;
      logic       last;
      logic [1:0] set_err;
   } cmd_type;

   function automatic logic [2:0] sym_to_tag(input logic [7:0] c);
      logic [2:0] t;
      case (c)
         CHAR_PLUS:  t = TAG_PLUS;
         CHAR_MINUS: t = TAG_MINUS;
         CHAR_MUL:   t = TAG_MUL;
         CHAR_DIV:   t = TAG_DIV;
         CHAR_POW:   t = TAG_POW;
         default:    t = TAG_OPEN;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] tag_to_char(input logic [2:0] t);
      logic [7:0] c;
      case (t)
         TAG_OPEN:  c = CHAR_OPEN;
         TAG_PLUS:  c = CHAR_PLUS;
         TAG_MINUS: c = CHAR_MINUS;
         TAG_MUL:   c = CHAR_MUL;
         TAG_DIV:   c = CHAR_DIV;
         TAG_POW:   c = CHAR_POW;
         default:   c = CHAR_NONE;
      endcase
      return c;
   endfunction

   // '(' ranks below every operator so it never pops
   function automatic logic [1:0] tag_prec(input logic [2:0] t);
      logic [1:0] p;
      case (t)
         TAG_PLUS, TAG_MINUS: p = 2'd1;
         TAG_MUL, TAG_DIV:    p = 2'd2;
         TAG_POW:             p = 2'd3;
         default:             p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

[rtl/core/infix_to_postfix_converter_unit.sv]
// an accepted transaction is captured in the item latch; its first result is then loaded
//   into the result register from the evaluate state, and no new input is taken until it is done;
//   the stack memory has registered reads, so each pop passes through a wait state
// an output stall holds the sequencer until the result register frees up
// reset: synchronous active high, clears stack count, error status and result valid;
//   stack memory contents are not cleared
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   // input channel: one character or end mark per transaction
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_expression,
   // result channel: postfix character or done marker
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_expr_done,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   i2p_pkg::status_type st;
   i2p_pkg::cmd_type    cmd;

   // sequencer: idle / evaluate / wait for stack read after a pop
   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // item latch, operator stack, error status and result register
   i2p_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_symbol            (req_symbol),
      .req_end_of_expression (req_end_of_expression),
      .cmd                   (cmd),
      .st                    (st),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_char          (rsp_out_char),
      .rsp_char_valid        (rsp_char_valid),
      .rsp_expr_done         (rsp_expr_done),
      .rsp_error_code        (rsp_error_code),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   // done marker always closes the run and carries no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done |-> rsp_last_of_run && !rsp_char_valid)
      else $error("done marker without last flag or with character");

   // error status only shows on the done marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != i2p_pkg::ERR_NONE) |-> rsp_expr_done)
      else $error("error code on a non-done result");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous transaction in work");

   // stack never reported both empty and full
   assert property (@(posedge clock) disable iff (reset)
      !(st.empty && st.full))
      else $error("stack empty and full at once");

endmodule

[rtl/core/i2p_ctrl.sv]
module i2p_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2p_pkg::status_type st,
   output i2p_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (st.out_free) begin
               state_in = S_IDLE;
               if (st.end_mark) begin
                  if (!st.err_active && !st.empty) begin
                     cmd.pop_emit = 1'b1;
                     state_in     = S_WAIT;
                  end else begin
                     cmd.done = 1'b1;
                     cmd.last = 1'b1;
                  end
               end else if (st.err_active) begin
                  // input ignored until end mark
               end else if (st.is_alnum) begin
                  cmd.emit_alnum = 1'b1;
                  cmd.last       = 1'b1;
               end else if (st.is_open) begin
                  if (st.full) cmd.set_err = i2p_pkg::ERR_OVERFLOW;
                  else cmd.push = 1'b1;
               end else if (st.is_close) begin
                  if (st.empty) begin
                     cmd.set_err = i2p_pkg::ERR_UNMATCHED;
                  end else if (st.top_open) begin
                     cmd.drop_open = 1'b1;
                  end else begin
                     cmd.pop_emit = 1'b1;
                     cmd.last     = st.close_last;
                     state_in     = S_WAIT;
                  end
               end else if (st.is_op) begin
                  if (!st.empty && !st.top_open && st.pop_ok) begin
                     cmd.pop_emit = 1'b1;
                     cmd.last     = st.op_last;
                     state_in     = S_WAIT;
                  end else if (st.full) begin
                     cmd.set_err = i2p_pkg::ERR_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
            end
         end
         S_WAIT: begin
            // stack read port catches up with the new count
            state_in = S_EVAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

[rtl/core/i2p_dpath.sv]
module i2p_dpath #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_symbol,
   input  logic                req_end_of_expression,
   input  i2p_pkg::cmd_type    cmd,
   output i2p_pkg::status_type st,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_char_valid,
   output logic                rsp_expr_done,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_last_of_run
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [2:0]    stack_mem [STACK_DEPTH];

   logic [7:0]    sym_ff;
   logic          end_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [1:0]    err_ff;
   logic [1:0]    err_in;
   logic [2:0]    top_ff;
   logic [2:0]    next_ff;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    out_char_ff;
   logic          char_valid_ff;
   logic          expr_done_ff;
   logic [1:0]    error_code_ff;
   logic          last_ff;

   logic [AW-1:0] top_addr;
   logic [AW-1:0] next_addr;
   logic [2:0]    sym_tag;
   logic [1:0]    sym_prec;
   logic          load_out;

   assign top_addr  = AW'(count_ff - CW'(1));
   assign next_addr = AW'(count_ff - CW'(2));
   assign sym_tag   = i2p_pkg::sym_to_tag(sym_ff);
   assign sym_prec  = i2p_pkg::tag_prec(sym_tag);

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sym_ff <= req_symbol;
         end_ff <= req_end_of_expression;
      end
   end

   // stack memory, two registered read ports at top and next below top
   always_ff @(posedge clock) begin
      if (cmd.push) stack_mem[count_ff[AW-1:0]] <= sym_tag;
      top_ff  <= stack_mem[top_addr];
      next_ff <= stack_mem[next_addr];
   end

   always_comb begin
      st.end_mark   = end_ff;
      st.err_active = (err_ff != i2p_pkg::ERR_NONE);
      st.is_alnum   = i2p_pkg::is_alnum(sym_ff);
      st.is_open    = (sym_ff == i2p_pkg::CHAR_OPEN);
      st.is_close   = (sym_ff == i2p_pkg::CHAR_CLOSE);
      st.is_op      = (sym_tag != i2p_pkg::TAG_OPEN);
      st.empty      = (count_ff == '0);
      st.full       = (count_ff == CW'(STACK_DEPTH));
      st.top_open   = (top_ff == i2p_pkg::TAG_OPEN);
      st.pop_ok     = (sym_prec <= i2p_pkg::tag_prec(top_ff));
      st.close_last = (count_ff == CW'(1)) || (next_ff == i2p_pkg::TAG_OPEN);
      st.op_last    = (count_ff == CW'(1)) || (sym_prec > i2p_pkg::tag_prec(next_ff));
      st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (cmd.done) begin
         count_in = '0;
         err_in   = i2p_pkg::ERR_NONE;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_emit || cmd.drop_open) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.set_err != i2p_pkg::ERR_NONE) err_in = cmd.set_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= i2p_pkg::ERR_NONE;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // result register
   assign load_out     = cmd.pop_emit || cmd.emit_alnum || cmd.done;
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         last_ff <= cmd.last;
         if (cmd.pop_emit) begin
            out_char_ff   <= i2p_pkg::tag_to_char(top_ff);
            char_valid_ff <= 1'b1;
            expr_done_ff  <= 1'b0;
            error_code_ff <= i2p_pkg::ERR_NONE;
         end else if (cmd.emit_alnum) begin
            out_char_ff   <= sym_ff;
            char_valid_ff <= 1'b1;
            expr_done_ff  <= 1'b0;
            error_code_ff <= i2p_pkg::ERR_NONE;
         end else begin
            out_char_ff   <= i2p_pkg::CHAR_NONE;
            char_valid_ff <= 1'b0;
            expr_done_ff  <= 1'b1;
            error_code_ff <= err_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_expr_done   = expr_done_ff;
   assign rsp_error_code  = error_code_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[dv/tb_infix_to_postfix_converter_unit.sv]
module tb_infix_to_postfix_converter_unit;

   localparam int STACK_DEPTH  = 32;
   localparam int RANDOM_ITEMS = 240;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   // one postfix result as seen on the rsp_ channel
   typedef struct packed {
      logic [7:0] ch;
      logic       cv;
      logic       done;
      logic [1:0] err;
      logic       last;
   } postfix_type;

   // one transaction on the req_ channel, with an optional hand-written result
   typedef struct packed {
      logic [7:0]  sym;
      logic        eoe;
      logic        typed;
      logic        typed_has;
      postfix_type typed_res;
   } symbol_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_symbol = 8'h00;
   logic       req_end_of_expression = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_expr_done;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;

   infix_to_postfix_converter_unit #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_symbol            (req_symbol),
      .req_end_of_expression (req_end_of_expression),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_char          (rsp_out_char),
      .rsp_char_valid        (rsp_char_valid),
      .rsp_expr_done         (rsp_expr_done),
      .rsp_error_code        (rsp_error_code),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // predictor state: operator stack, fill level and sticky error
   logic [2:0]   op_stack [STACK_DEPTH];
   int unsigned  stack_fill = 0;
   logic [1:0]   sticky_err = i2p_pkg::ERR_NONE;

   symbol_item_type pending_symbols [$];
   postfix_type     expected_postfix [$];
   postfix_type     step_results [$];
   logic [7:0]      expr_chars [$];
   symbol_item_type directed_rows [25];

   int  cycle_count     = 0;
   int  mismatch_count  = 0;
   int  checked_count   = 0;
   int  random_acted    = 0;
   int  random_sent     = 0;
   int  directed_count  = 0;
   int  expr_count      = 0;
   int  overflow_seen   = 0;
   int  unmatched_seen  = 0;
   int  deepest_run     = 0;
   int  run_len         = 0;
   bit  random_phase    = 0;
   bit  quiet_tail      = 0;
   bit  tx_calm         = 0;
   bit  rx_calm         = 0;
   int  rx_stall_left   = 0;

   function automatic logic [2:0] tag_of_symbol(input logic [7:0] c);
      case (c)
         i2p_pkg::CHAR_PLUS:  return i2p_pkg::TAG_PLUS;
         i2p_pkg::CHAR_MINUS: return i2p_pkg::TAG_MINUS;
         i2p_pkg::CHAR_MUL:   return i2p_pkg::TAG_MUL;
         i2p_pkg::CHAR_DIV:   return i2p_pkg::TAG_DIV;
         i2p_pkg::CHAR_POW:   return i2p_pkg::TAG_POW;
         default:             return i2p_pkg::TAG_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] char_of_tag(input logic [2:0] t);
      case (t)
         i2p_pkg::TAG_PLUS:  return i2p_pkg::CHAR_PLUS;
         i2p_pkg::TAG_MINUS: return i2p_pkg::CHAR_MINUS;
         i2p_pkg::TAG_MUL:   return i2p_pkg::CHAR_MUL;
         i2p_pkg::TAG_DIV:   return i2p_pkg::CHAR_DIV;
         i2p_pkg::TAG_POW:   return i2p_pkg::CHAR_POW;
         default:            return i2p_pkg::CHAR_OPEN;
      endcase
   endfunction

   // open paren ranks lowest so it stops every pop
   function automatic int unsigned rank_of(input logic [2:0] t);
      if (t == i2p_pkg::TAG_POW) return 3;
      if (t == i2p_pkg::TAG_MUL || t == i2p_pkg::TAG_DIV) return 2;
      if (t == i2p_pkg::TAG_PLUS || t == i2p_pkg::TAG_MINUS) return 1;
      return 0;
   endfunction

   function automatic void pop_to_output();
      postfix_type r;
      stack_fill--;
      r = '0;
      r.ch = char_of_tag(op_stack[stack_fill]);
      r.cv = 1'b1;
      step_results.push_back(r);
   endfunction

   // advance the shunting-yard state by one symbol, results land in step_results
   function automatic bit convert_symbol(input logic [7:0] c, input logic eoe);
      postfix_type r;
      logic [2:0]  t;
      bit          acted;
      acted = 1;
      step_results.delete();
      t = tag_of_symbol(c);
      if (eoe) begin
         if (sticky_err == i2p_pkg::ERR_NONE) begin
            while (stack_fill > 0) pop_to_output();
         end
         r = '0;
         r.done = 1'b1;
         r.err = sticky_err;
         step_results.push_back(r);
         stack_fill = 0;
         sticky_err = i2p_pkg::ERR_NONE;
      end else if (sticky_err != i2p_pkg::ERR_NONE) begin
         acted = 0;
      end else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z")) begin
         r = '0;
         r.ch = c;
         r.cv = 1'b1;
         step_results.push_back(r);
      end else if (c == i2p_pkg::CHAR_OPEN) begin
         if (stack_fill >= STACK_DEPTH) sticky_err = i2p_pkg::ERR_OVERFLOW;
         else begin
            op_stack[stack_fill] = i2p_pkg::TAG_OPEN;
            stack_fill++;
         end
      end else if (c == i2p_pkg::CHAR_CLOSE) begin
         while (stack_fill > 0 && op_stack[stack_fill - 1] != i2p_pkg::TAG_OPEN)
            pop_to_output();
         if (stack_fill == 0) sticky_err = i2p_pkg::ERR_UNMATCHED;
         else stack_fill--;
      end else if (t != i2p_pkg::TAG_OPEN) begin
         while (stack_fill > 0 && rank_of(t) <= rank_of(op_stack[stack_fill - 1]))
            pop_to_output();
         if (stack_fill >= STACK_DEPTH) sticky_err = i2p_pkg::ERR_OVERFLOW;
         else begin
            op_stack[stack_fill] = t;
            stack_fill++;
         end
      end else begin
         acted = 0;
      end
      if (step_results.size() > 0) step_results[$].last = 1'b1;
      return acted;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // timeout, request-side prediction and result-side checking
   always @(posedge clock) begin
      symbol_item_type it;
      postfix_type     e;
      bit              acted;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_postfix.size());
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         // transaction accepted: predict, or take the hand-typed result
         if (req_valid && req_ready) begin
            it = pending_symbols.pop_front();
            acted = convert_symbol(it.sym, it.eoe);
            if (random_phase) random_sent++;
            if (random_phase && acted) random_acted++;
            if (!random_phase) directed_count++;
            if (it.eoe) expr_count++;
            if (it.typed) begin
               if (it.typed_has) expected_postfix.push_back(it.typed_res);
            end else begin
               foreach (step_results[i]) expected_postfix.push_back(step_results[i]);
            end
            if (step_results.size() > deepest_run) deepest_run = step_results.size();
         end
         // result accepted: compare against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_postfix.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h/%0b/%0d",
                        $time, rsp_out_char, rsp_expr_done, rsp_error_code);
               mismatch_count++;
            end else begin
               e = expected_postfix.pop_front();
               checked_count++;
               if (e.done && e.err == i2p_pkg::ERR_OVERFLOW) overflow_seen++;
               if (e.done && e.err == i2p_pkg::ERR_UNMATCHED) unmatched_seen++;
               check_field("out_char", e.ch, rsp_out_char);
               check_field("char_valid", e.cv, rsp_char_valid);
               check_field("expr_done", e.done, rsp_expr_done);
               check_field("error_code", e.err, rsp_error_code);
               check_field("last_of_run", e.last, rsp_last_of_run);
            end
         end
      end
   end

   // result side backpressure in random bursts, calm stretches in between
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_ready <= 1'b1;
      end else if (rx_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) rx_calm <= ~rx_calm;
   end

   // drive one transaction and return at the edge where it is taken
   task automatic send_item(input logic [7:0] sym, input logic eoe, input logic typed,
                            input logic typed_has, input postfix_type typed_res);
      symbol_item_type it;
      if (!quiet_tail && !tx_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      it.sym = sym;
      it.eoe = eoe;
      it.typed = typed;
      it.typed_has = typed_has;
      it.typed_res = typed_res;
      pending_symbols.push_back(it);
      req_valid <= 1'b1;
      req_symbol <= sym;
      req_end_of_expression <= eoe;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_postfix.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_operand();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(8'h30, 8'h39));
         1:       return 8'($urandom_range(8'h41, 8'h5A));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 4))
         0:       return i2p_pkg::CHAR_PLUS;
         1:       return i2p_pkg::CHAR_MINUS;
         2:       return i2p_pkg::CHAR_MUL;
         3:       return i2p_pkg::CHAR_DIV;
         default: return i2p_pkg::CHAR_POW;
      endcase
   endfunction

   // well-formed infix text with random nesting and stray blanks
   task automatic build_expression();
      int  operands;
      int  target;
      int  open_cnt;
      bit  want_operand;
      operands = 0;
      open_cnt = 0;
      want_operand = 1;
      target = $urandom_range(1, 10);
      expr_chars.delete();
      forever begin
         if (want_operand) begin
            if (open_cnt < 6 && $urandom_range(0, 3) == 0) begin
               expr_chars.push_back(i2p_pkg::CHAR_OPEN);
               open_cnt++;
            end else begin
               expr_chars.push_back(random_operand());
               if ($urandom_range(0, 7) == 0)
                  expr_chars.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
               operands++;
               want_operand = 0;
            end
         end else if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
            expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
            open_cnt--;
         end else if (operands >= target) begin
            break;
         end else begin
            expr_chars.push_back(random_operator());
            want_operand = 1;
         end
      end
      // leave some parens open so the flush has to pop them
      while (open_cnt > 0 && $urandom_range(0, 4) != 0) begin
         expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
         open_cnt--;
      end
   endtask

   initial begin
      int mode;
      int n;
      int k;
      bit paused_once;
      paused_once = 0;

      // directed rows: {symbol, end, typed, has result, {char, cv, done, err, last}}
      directed_rows = '{
         '{8'hFF, 1'b1, 1'b1, 1'b1,
           '{i2p_pkg::CHAR_NONE, 1'b0, 1'b1, i2p_pkg::ERR_NONE, 1'b1}},
         '{"0", 1'b0, 1'b1, 1'b1, '{"0", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_PLUS,  1'b0, 1'b0, 1'b0, '0},
         '{"9", 1'b0, 1'b1, 1'b1, '{"9", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_MUL,   1'b0, 1'b0, 1'b0, '0},
         '{"z", 1'b0, 1'b1, 1'b1, '{"z", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_POW,   1'b0, 1'b0, 1'b0, '0},
         '{"A", 1'b0, 1'b1, 1'b1, '{"A", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_MINUS, 1'b0, 1'b0, 1'b0, '0},
         '{i2p_pkg::CHAR_OPEN,  1'b0, 1'b0, 1'b0, '0},
         '{"a", 1'b0, 1'b1, 1'b1, '{"a", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_DIV,   1'b0, 1'b0, 1'b0, '0},
         '{8'h20,               1'b0, 1'b1, 1'b0, '0},
         '{8'h09,               1'b0, 1'b1, 1'b0, '0},
         '{"Z", 1'b0, 1'b1, 1'b1, '{"Z", 1'b1, 1'b0, i2p_pkg::ERR_NONE, 1'b1}},
         '{i2p_pkg::CHAR_CLOSE, 1'b0, 1'b0, 1'b0, '0},
         '{8'h80,               1'b0, 1'b1, 1'b0, '0},
         '{i2p_pkg::CHAR_POW,   1'b0, 1'b0, 1'b0, '0},
         '{8'h00,               1'b1, 1'b0, 1'b0, '0},
         '{"x",                 1'b0, 1'b0, 1'b0, '0},
         '{i2p_pkg::CHAR_PLUS,  1'b0, 1'b0, 1'b0, '0},
         '{"y",                 1'b0, 1'b0, 1'b0, '0},
         '{i2p_pkg::CHAR_CLOSE, 1'b0, 1'b0, 1'b0, '0},
         '{"q",                 1'b0, 1'b1, 1'b0, '0},
         '{8'h7F, 1'b1, 1'b1, 1'b1,
           '{i2p_pkg::CHAR_NONE, 1'b0, 1'b1, i2p_pkg::ERR_UNMATCHED, 1'b1}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].sym, directed_rows[i].eoe, directed_rows[i].typed,
                   directed_rows[i].typed_has, directed_rows[i].typed_res);

      // hold off until the directed results are all back
      wait_for_drain();
      random_phase = 1;

      while (random_sent < RANDOM_ITEMS) begin
         if (!paused_once && random_sent >= RANDOM_ITEMS / 2) begin
            paused_once = 1;
            wait_for_drain();
         end
         quiet_tail = (random_sent >= RANDOM_ITEMS * 5 / 6);
         tx_calm = ($urandom_range(0, 4) == 0);
         mode = $urandom_range(0, 9);
         expr_chars.delete();
         case (mode)
            6: begin
               // deep nesting around the stack limit, overflow on the far side
               n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
               repeat (n) expr_chars.push_back(i2p_pkg::CHAR_OPEN);
               if ($urandom_range(0, 1)) expr_chars.push_back(random_operator());
               if ($urandom_range(0, 1)) expr_chars.push_back(random_operand());
            end
            7: begin
               repeat ($urandom_range(1, 10)) expr_chars.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
               // well-formed text with one symbol broken
               build_expression();
               k = $urandom_range(0, expr_chars.size() - 1);
               case ($urandom_range(0, 3))
                  0:       expr_chars[k] = i2p_pkg::CHAR_CLOSE;
                  1:       expr_chars[k] = i2p_pkg::CHAR_OPEN;
                  2:       expr_chars[k] = random_operator();
                  default: expr_chars[k] = 8'($urandom_range(0, 255));
               endcase
               if ($urandom_range(0, 2) == 0) expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
            end
            9: ;
            default: build_expression();
         endcase
         foreach (expr_chars[j]) send_item(expr_chars[j], 1'b0, 1'b0, 1'b0, '0);
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random transactions (%0d effective), %0d checked",
               directed_count, random_sent, random_acted, checked_count);
      $display("%0d expressions, %0d overflows, %0d unmatched parens, longest run %0d results",
               expr_count, overflow_seen, unmatched_seen, deepest_run);
      if (mismatch_count == 0 && expected_postfix.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, expected_postfix.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
